// ===== rtl/erlang_c_residence_time_top_macros.svh =====
// assertion macros used by the checker of this block
`ifndef ERLANG_C_RESIDENCE_TIME_TOP_MACROS_SVH
`define ERLANG_C_RESIDENCE_TIME_TOP_MACROS_SVH

// same-cycle implication, quiet during reset
`define ERCRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define ERCRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define ERCRT_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ercrt_pkg.sv =====
package ercrt_pkg;

  // widths of the interface fields
  localparam int unsigned RateW   = 32;
  localparam int unsigned ServerW = 11;

  // largest server count honored; larger requests are clamped
  localparam logic [ServerW-1:0] MAX_SERVERS = 11'd1024;

  // internal widths: load below 2^42, divisors below 2^44
  localparam int unsigned LoadW = 42;
  localparam int unsigned DivW  = 44;
  localparam int unsigned DvdW  = 64;
  localparam int unsigned CntW  = 7;

  // 1.0 in the 32-fraction-bit format
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  // iteration counts of the divider
  localparam logic [CntW-1:0] ITERS_Q32 = 7'd32;
  localparam logic [CntW-1:0] ITERS_INT = 7'd64;

  typedef struct packed {
    logic [RateW-1:0]   arrival_rate;
    logic [RateW-1:0]   service_time;
    logic [ServerW-1:0] server_count;
  } in_t;

  typedef struct packed {
    logic [RateW-1:0] residence_time;
    logic             saturated;
  } out_t;

  // request to the shared divider
  typedef struct packed {
    logic            start;
    logic [DivW-1:0] rem_init;
    logic [DvdW-1:0] dividend;
    logic [DivW-1:0] divisor;
    logic [CntW-1:0] iters;
  } div_req_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic            done;
    logic [DvdW-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/ercrt_mul.sv =====
// shared 32x32 multiplier, product registered
module ercrt_mul (
  input  logic        clk,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  output logic [63:0] prod
);

  always_ff @(posedge clk) begin
    prod <= 64'(op_a) * 64'(op_b);
  end

endmodule

// ===== rtl/ercrt_div.sv =====
// shared restoring divider, one quotient bit per cycle
module ercrt_div (
  input  logic                clk,
  input  logic                rst,
  input  ercrt_pkg::div_req_t req,
  output ercrt_pkg::div_rsp_t rsp
);

  logic                            busy;
  logic                            done;
  logic [ercrt_pkg::DivW-1:0]      rem;
  logic [ercrt_pkg::DvdW-1:0]      dvd;
  logic [ercrt_pkg::DivW-1:0]      dsr;
  logic [ercrt_pkg::DvdW-1:0]      quo;
  logic [ercrt_pkg::CntW-1:0]      cnt;
  logic [ercrt_pkg::DivW:0]        shifted;
  logic                            ge;
  logic [ercrt_pkg::DivW-1:0]      rem_next;

  // trial subtract of the shifted remainder
  always_comb begin
    shifted  = {rem, dvd[ercrt_pkg::DvdW-1]};
    ge       = shifted >= {1'b0, dsr};
    rem_next = ge ? ercrt_pkg::DivW'(shifted - {1'b0, dsr})
                  : shifted[ercrt_pkg::DivW-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == ercrt_pkg::CntW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem_init;
      dvd <= req.dividend;
      dsr <= req.divisor;
      cnt <= req.iters;
      quo <= '0;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[ercrt_pkg::DvdW-2:0], 1'b0};
      quo <= {quo[ercrt_pkg::DvdW-2:0], ge};
      cnt <= cnt - ercrt_pkg::CntW'(1);
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ===== rtl/erlang_c_residence_time_top.sv =====
// Mean residence time of an M/M/m queue through Erlang B and Erlang C.
// Input channel in_valid/in_ready/in_data carries arrival rate and service
// time (unsigned Q16.16) and the server count m; output channel
// out_valid/out_ready/out_data carries the residence time (Q16.16) and a
// saturation flag. One transaction in gives exactly one transaction out.
// The block works on one item at a time: in_ready is high only while idle.
// Each Erlang B step runs the shared 32x32 multiplier (ST_MUL_LO, ST_MUL_HI,
// ST_MUL_SUM), a divider launch, the shared one-bit-per-cycle divider and
// an update; the final wait is an integer division. A saturated item
// (load at or above m, or m of zero) skips the recursion and returns all
// ones. Counts above 1024 are clamped to 1024. A new item is accepted
// only once the previous one has left the sequencer.
// The result sits in an output register; when the receiver stalls it holds
// there and the next item may be accepted meanwhile, but that item's
// result waits until the register is free. Synchronous reset returns the
// block to idle and drops any result not yet taken.
module erlang_c_residence_time_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ercrt_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output ercrt_pkg::out_t out_data
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_E, ST_CHECK, ST_MUL_LO, ST_MUL_HI, ST_MUL_SUM, ST_MUL_MB,
    ST_PREP_C, ST_MUL_SC, ST_PREP_W, ST_DIV_START, ST_DIV_WAIT, ST_POST, ST_DONE
  } state_t;

  typedef enum logic [1:0] {PH_B, PH_C, PH_W} phase_t;

  state_t                          state;
  phase_t                          phase;
  logic [31:0]                     arr;
  logic [31:0]                     svc;
  logic [ercrt_pkg::ServerW-1:0]   m;
  logic [ercrt_pkg::LoadW-1:0]     e;
  logic [32:0]                     b;
  logic [ercrt_pkg::ServerW-1:0]   k;
  logic [31:0]                     acc;
  logic [42:0]                     p;
  logic [ercrt_pkg::DivW-1:0]      nreg;
  logic [ercrt_pkg::DivW-1:0]      dreg;
  logic [ercrt_pkg::DvdW-1:0]      sc;
  logic [ercrt_pkg::DvdW-1:0]      quot;
  ercrt_pkg::out_t                 result;

  logic [31:0]                     mul_a;
  logic [31:0]                     mul_b;
  logic [63:0]                     prod;
  ercrt_pkg::div_req_t             div_req;
  ercrt_pkg::div_rsp_t             div_rsp;

  logic [42:0]                     p_next;
  logic [ercrt_pkg::DivW-1:0]      m_sh;
  logic [64:0]                     sum;
  logic                            q_sat;

  ercrt_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  ercrt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // operand select for the shared multiplier
  always_comb begin
    mul_a = b[31:0];
    mul_b = e[31:0];
    unique case (state)
      ST_MUL_E:  begin mul_a = arr;      mul_b = svc; end
      ST_MUL_LO: begin mul_a = b[31:0];  mul_b = e[31:0]; end
      ST_MUL_HI: begin mul_a = b[31:0];  mul_b = 32'(e[ercrt_pkg::LoadW-1:32]); end
      ST_MUL_MB: begin mul_a = b[31:0];  mul_b = 32'(m); end
      ST_MUL_SC: begin mul_a = svc;      mul_b = quot[31:0]; end
      default:   begin mul_a = b[31:0];  mul_b = e[31:0]; end
    endcase
  end

  // helper values
  always_comb begin
    m_sh   = {1'b0, m, 32'b0};
    p_next = b[32] ? 43'(e) : (43'(acc) + prod[42:0]);
    sum    = 65'(svc) + 65'(quot);
    q_sat  = (dreg == '0) || (nreg >= dreg);
  end

  // divider launch
  always_comb begin
    div_req.start    = 1'b0;
    div_req.rem_init = nreg;
    div_req.dividend = '0;
    div_req.divisor  = dreg;
    div_req.iters    = ercrt_pkg::ITERS_Q32;
    if (state == ST_DIV_START) begin
      if (phase == PH_W) begin
        div_req.start    = 1'b1;
        div_req.rem_init = '0;
        div_req.dividend = sc;
        div_req.iters    = ercrt_pkg::ITERS_INT;
      end else begin
        div_req.start = !q_sat;
      end
    end
  end

  assign in_ready = (state == ST_IDLE);

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_B;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            arr   <= in_data.arrival_rate;
            svc   <= in_data.service_time;
            m     <= (in_data.server_count > ercrt_pkg::MAX_SERVERS)
                     ? ercrt_pkg::MAX_SERVERS : in_data.server_count;
            state <= ST_MUL_E;
          end
        end
        ST_MUL_E: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (prod[63:32] >= 32'(m)) begin
            result.residence_time <= '1;
            result.saturated      <= 1'b1;
            state                 <= ST_DONE;
          end else begin
            e      <= prod[ercrt_pkg::LoadW-1:0];
            k      <= ercrt_pkg::ServerW'(1);
            nreg   <= ercrt_pkg::DivW'(prod[ercrt_pkg::LoadW-1:0]);
            dreg   <= ercrt_pkg::DivW'(prod[ercrt_pkg::LoadW-1:0])
                      + ercrt_pkg::DivW'(ercrt_pkg::ONE_Q32);
            phase  <= PH_B;
            state  <= ST_DIV_START;
          end
        end
        ST_MUL_LO: begin
          state <= ST_MUL_HI;
        end
        ST_MUL_HI: begin
          acc   <= prod[63:32];
          state <= ST_MUL_SUM;
        end
        ST_MUL_SUM: begin
          if (phase == PH_B) begin
            nreg  <= ercrt_pkg::DivW'(p_next);
            dreg  <= {1'b0, k, 32'b0} + ercrt_pkg::DivW'(p_next);
            state <= ST_DIV_START;
          end else begin
            p     <= p_next;
            state <= ST_MUL_MB;
          end
        end
        ST_MUL_MB: begin
          state <= ST_PREP_C;
        end
        ST_PREP_C: begin
          // numerator m*B, denominator m - E + E*B
          nreg  <= prod[ercrt_pkg::DivW-1:0] + (b[32] ? m_sh : '0);
          dreg  <= m_sh - ercrt_pkg::DivW'(e) + ercrt_pkg::DivW'(p);
          state <= ST_DIV_START;
        end
        ST_MUL_SC: begin
          state <= ST_PREP_W;
        end
        ST_PREP_W: begin
          // service time times C over m - E
          sc    <= quot[32] ? {svc, 32'b0} : prod;
          dreg  <= m_sh - ercrt_pkg::DivW'(e);
          phase <= PH_W;
          state <= ST_DIV_START;
        end
        ST_DIV_START: begin
          if (phase != PH_W && q_sat) begin
            quot  <= ercrt_pkg::DvdW'(ercrt_pkg::ONE_Q32);
            state <= ST_POST;
          end else begin
            state <= ST_DIV_WAIT;
          end
        end
        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            quot  <= div_rsp.quotient;
            state <= ST_POST;
          end
        end
        ST_POST: begin
          unique case (phase)
            PH_B: begin
              b <= quot[32:0];
              if (k == m) begin
                phase <= PH_C;
              end else begin
                k <= k + ercrt_pkg::ServerW'(1);
              end
              state <= ST_MUL_LO;
            end
            PH_C: begin
              state <= ST_MUL_SC;
            end
            default: begin
              result.residence_time <= sum[64:32] != '0 ? '1 : sum[31:0];
              result.saturated      <= 1'b0;
              state                 <= ST_DONE;
            end
          endcase
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_data  <= result;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/ercrt_checker.sv =====
`include "erlang_c_residence_time_top_macros.svh"

// port-level checks of the residence time block
module ercrt_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input ercrt_pkg::in_t  in_data,
  input logic            out_valid,
  input logic            out_ready,
  input ercrt_pkg::out_t out_data
);

  // a saturated answer carries the maximum time
  `ERCRT_ASSERT_NOW(a_sat_max, out_valid && out_data.saturated, out_data.residence_time == '1, "saturated result not all ones")

  // one item at a time: busy right after an accepted transaction
  `ERCRT_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "ready right after accept")

  // a stalled result stays offered
  `ERCRT_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result dropped")

  // reset leaves nothing on the output and the block idle
  `ERCRT_ASSERT_ALWAYS(a_reset, rst, !out_valid && in_ready, "output or busy after reset")

endmodule

bind erlang_c_residence_time_top ercrt_checker u_ercrt_checker (.*);

// ===== sim/erlang_c_residence_time_top_tb.sv =====
`default_nettype none

module erlang_c_residence_time_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] UNIT = 64'h1_0000_0000;

  // queue model: Erlang B recursion, Erlang C and mean residence time
  class residence_scoreboard;
    ercrt_pkg::out_t awaited[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned sat_seen;
    int unsigned ovf_seen;

    // floor(x*y / 2^32)
    function logic [63:0] frac_mul(logic [63:0] x, logic [63:0] y);
      logic [127:0] t;
      t = {64'd0, x} * {64'd0, y};
      return t[95:32];
    endfunction

    // floor(n*2^32 / d), held at 1.0
    function logic [63:0] frac_div(logic [63:0] n, logic [63:0] d);
      logic [127:0] t;
      if (d == 0 || n >= d) return UNIT;
      t = {32'd0, n, 32'd0} / {64'd0, d};
      return t[63:0];
    endfunction

    function ercrt_pkg::out_t residence(ercrt_pkg::in_t x);
      logic [63:0] a, s, m, load, blk, wq, p, den, w;
      ercrt_pkg::out_t r;
      a = 64'(x.arrival_rate);
      s = 64'(x.service_time);
      m = 64'(x.server_count);
      if (m > 64'(ercrt_pkg::MAX_SERVERS)) m = 64'(ercrt_pkg::MAX_SERVERS);
      load = a * s;
      if (load >= (m << 32)) begin
        r.residence_time = '1;
        r.saturated = 1'b1;
        return r;
      end
      blk = frac_div(load, UNIT + load);
      for (logic [63:0] k = 2; k <= m; k++) begin
        p = frac_mul(blk, load);
        blk = frac_div(p, (k << 32) + p);
      end
      wq = frac_div(m * blk, (m << 32) - load + frac_mul(blk, load));
      den = (m << 32) - load;
      w = (s * wq) / den;
      r.saturated = 1'b0;
      if (w > 64'hFFFF_FFFF - s) r.residence_time = '1;
      else r.residence_time = 32'(s + w);
      return r;
    endfunction

    function void note_input(ercrt_pkg::in_t x);
      awaited.push_back(residence(x));
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    endtask

    task check_result(ercrt_pkg::out_t r);
      ercrt_pkg::out_t e;
      checked++;
      if (awaited.size() == 0) begin
        report("unexpected transaction", r.residence_time, 32'd0);
        return;
      end
      e = awaited.pop_front();
      if (r.residence_time !== e.residence_time)
        report("residence_time", r.residence_time, e.residence_time);
      if (r.saturated !== e.saturated)
        report("saturated", 32'(r.saturated), 32'(e.saturated));
      if (e.saturated) sat_seen++;
      else if (e.residence_time == '1) ovf_seen++;
    endtask
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_ready;
  ercrt_pkg::in_t  in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  ercrt_pkg::out_t out_data;

  residence_scoreboard sb = new();
  bit          no_idle = 1'b0;
  int unsigned sent = 0;

  erlang_c_residence_time_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #10 clk = ~clk;

  // mostly short gaps, a few long ones
  function int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // one input transaction; valid drops afterwards only when idling or asked
  task send_item(ercrt_pkg::in_t x, bit hold_off);
    int unsigned gap;
    in_data  <= x;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(x);
    sent++;
    gap = pick_gap();
    if (hold_off || gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task drain();
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  function ercrt_pkg::in_t mk(logic [31:0] a, logic [31:0] s, logic [10:0] m);
    ercrt_pkg::in_t x;
    x.arrival_rate = a;
    x.service_time = s;
    x.server_count = m;
    return x;
  endfunction

  // random item, mostly below saturation so the recursion runs
  function ercrt_pkg::in_t random_item();
    ercrt_pkg::in_t x;
    logic [63:0] mc, s, lim;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) x.server_count = 11'($urandom_range(1, 12));
    else if (r < 95) x.server_count = 11'($urandom_range(13, 64));
    else if (r < 98) x.server_count = 11'($urandom_range(65, 1024));
    else x.server_count = 11'($urandom_range(1025, 2047));
    if ($urandom_range(0, 99) < 20) begin
      x.arrival_rate = $urandom;
      x.service_time = $urandom >> $urandom_range(0, 31);
      if ($urandom_range(0, 3) == 0) x.server_count = 11'($urandom);
      return x;
    end
    mc = (x.server_count > ercrt_pkg::MAX_SERVERS) ? 64'(ercrt_pkg::MAX_SERVERS)
                                                    : 64'(x.server_count);
    s = 64'($urandom >> $urandom_range(0, 31));
    if (s == 0) s = 1;
    lim = ((mc << 32) - 1) / s + 1;
    if (lim > 64'hFFFF_FFFF) x.arrival_rate = $urandom;
    else x.arrival_rate = 32'(64'($urandom) % lim);
    x.arrival_rate = x.arrival_rate >> ($urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0);
    x.service_time = 32'(s);
    return x;
  endfunction

  // receiver: check on handshake, then stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if ($urandom_range(0, 99) < 3) out_ready <= 1'b0;
      else if (!out_ready && $urandom_range(0, 99) < 25) out_ready <= 1'b1;
      else if (no_idle) out_ready <= 1'b1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners
    send_item(mk(32'h0, 32'h0001_0000, 11'd4), 0);          // zero load
    send_item(mk(32'h0001_0000, 32'h0001_0000, 11'd0), 0);  // zero servers
    send_item(mk(32'h0, 32'h0, 11'd0), 0);
    send_item(mk(32'h0001_0000, 32'h0001_0000, 11'd1), 0);  // load exactly m
    send_item(mk(32'h0000_FFFF, 32'h0001_0000, 11'd1), 0);  // just below m
    send_item(mk(32'h0000_0001, 32'hFFFF_FFFF, 11'd1), 0);  // result overflow
    send_item(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd2047), 0);
    send_item(mk(32'hFFFF_FFFF, 32'h0000_0001, 11'd1), 0);
    send_item(mk(32'h0003_0000, 32'h0000_8000, 11'd2), 0);
    send_item(mk(32'h0200_0000, 32'h0001_0000, 11'd1024), 0); // full recursion
    send_item(mk(32'h0400_0000, 32'h0001_0000, 11'd2047), 0); // clamped to max
    send_item(mk(32'h0400_0000, 32'h0001_0000, 11'd1500), 0); // saturates after clamp
    send_item(mk(32'h0001_0000, 32'h0000_0001, 11'd1), 1);
    drain();

    // random, first stretch with no idling on either side
    no_idle = 1'b1;
    for (int i = 0; i < 100; i++) begin
      if (i == 20) no_idle = 1'b0;
      send_item(random_item(), i == 50 || i == 99);
      if (i == 50) drain();
    end

    drain();
    repeat (200) @(posedge clk);
    $display("covered %0d transactions: %0d saturated, %0d with result overflow",
             sb.checked, sb.sat_seen, sb.ovf_seen);
    $display("loads up to and past the server count, server counts 0 to 2047 with clamping");
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000_000;
    $display("timeout with %0d transactions outstanding", sb.awaited.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
